[src/ple_pkg.sv]
// shared types, constants and ring index helper for the positional list engine
// no dependencies

package ple_pkg;

    localparam int CAPACITY  = 64;
    localparam int WORD_BITS = 32;

    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int MODE_W   = 4;
    localparam int STATUS_W = 3;

    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(CAPACITY - 1);

    // request codes
    localparam logic [MODE_W-1:0] OP_INS_FRONT = 4'd0;
    localparam logic [MODE_W-1:0] OP_INS_END   = 4'd1;
    localparam logic [MODE_W-1:0] OP_INS_AT    = 4'd2;
    localparam logic [MODE_W-1:0] OP_DEL_FRONT = 4'd3;
    localparam logic [MODE_W-1:0] OP_DEL_END   = 4'd4;
    localparam logic [MODE_W-1:0] OP_DEL_AT    = 4'd5;
    localparam logic [MODE_W-1:0] OP_SEARCH    = 4'd6;
    localparam logic [MODE_W-1:0] OP_LIST_FWD  = 4'd7;
    localparam logic [MODE_W-1:0] OP_LIST_BACK = 4'd8;
    localparam logic [MODE_W-1:0] OP_COUNT     = 4'd9;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    // one access slot of the entry store, logical indexes relative to the ring start
    typedef struct packed {
        logic                 rd_en;
        logic [CNT_W-1:0]     rd_idx;
        logic                 wr_en;
        logic [CNT_W-1:0]     wr_idx;
        logic [WORD_BITS-1:0] wr_data;
    } ple_mem_req_t;

    // physical slot of a logical index: add and wrap once
    function automatic logic [IDX_W-1:0] ring_idx(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(CAPACITY))
        begin
            sum = sum - (CNT_W + 1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

[src/positional_list_engine.sv]
// top level of the positional list engine: request decode, sequencer and result register
// depends on ple_pkg and ple_store
//
// channel   direction  handshake            payload
// request   in         start & !busy        mode, position, item_value
// result    out        done (one cycle)     status, result_value, result_position,
//                                           entry_count, last
//
// - front/end insert, insert at 0 or at the count, refusals (empty, bad position, full)
//   and count finish at the accept edge; result shows next cycle, busy never rises
// - delete at front or end (or at the first or last position): a single memory read
// - insert/delete at a position: the store has one read and one write port, so
//   the tail moves one entry at a time, each read and then written one place over
// - search and list walk one entry per cycle, listing gives one result per cycle
// - reset clears only the control registers, not the store; the receiver cannot stall results

module positional_list_engine
    import ple_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [MODE_W-1:0]           mode,
    input  logic [CNT_W-1:0]            position,
    input  logic signed [WORD_BITS-1:0] item_value,
    output logic                        done,
    output logic [STATUS_W-1:0]         status,
    output logic signed [WORD_BITS-1:0] result_value,
    output logic [IDX_W-1:0]            result_position,
    output logic [CNT_W-1:0]            entry_count,
    output logic                        last
);

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_WALK  = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     ring_reg, ring_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [WORD_BITS-1:0] item_reg, item_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [WORD_BITS-1:0] val_reg, val_next;

    // walk control: cursor of the next read and the tag of the read in flight
    logic [CNT_W-1:0]     cur_reg, cur_next;
    logic [CNT_W-1:0]     stop_reg, stop_next;
    logic                 up_reg, up_next;
    logic                 more_reg, more_next;
    logic                 pend_reg, pend_next;
    logic [CNT_W-1:0]     pend_idx_reg, pend_idx_next;

    // result register
    logic                 done_reg, done_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [WORD_BITS-1:0] value_reg, value_next;
    logic [IDX_W-1:0]     rpos_reg, rpos_next;
    logic                 last_reg, last_next;

    ple_mem_req_t         req;
    logic [WORD_BITS-1:0] rd_data;
    logic                 accept;
    logic [CNT_W-1:0]     ins_pos;
    logic [CNT_W-1:0]     del_pos;

    ple_store u_store (
        .clk     (clk),
        .ring    (ring_reg),
        .req     (req),
        .rd_data (rd_data)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // effective target positions of the front/end forms
    always_comb
    begin
        priority if (mode == OP_INS_FRONT)
        begin
            ins_pos = '0;
        end
        else if (mode == OP_INS_END)
        begin
            ins_pos = count_reg;
        end
        else
        begin
            ins_pos = position;
        end

        priority if (mode == OP_DEL_FRONT)
        begin
            del_pos = '0;
        end
        else if (mode == OP_DEL_END)
        begin
            del_pos = count_reg - 1'b1;
        end
        else
        begin
            del_pos = position;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ring_next     = ring_reg;
        mode_next     = mode_reg;
        item_next     = item_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        cur_next      = cur_reg;
        stop_next     = stop_reg;
        up_next       = up_reg;
        more_next     = more_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        value_next    = value_reg;
        rpos_next     = rpos_reg;
        last_next     = last_reg;
        req           = '0;
        req.wr_data   = item_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next = mode;
                    item_next = item_value;
                    pend_next = 1'b0;
                    unique case (mode)
                        OP_INS_FRONT, OP_INS_END, OP_INS_AT:
                        begin
                            done_next  = 1'b1;
                            last_next  = 1'b1;
                            value_next = '0;
                            rpos_next  = '0;
                            priority if (mode == OP_INS_AT && position > count_reg)
                            begin
                                status_next = ST_BAD_POS;
                            end
                            else if (count_reg == CAP_CNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (ins_pos == '0 && count_reg != '0)
                            begin
                                // new front lands one slot before the ring start
                                req.wr_en   = 1'b1;
                                req.wr_idx  = LAST_IDX;
                                req.wr_data = item_value;
                                ring_next   = (ring_reg == '0) ? IDX_W'(CAPACITY - 1)
                                                               : ring_reg - 1'b1;
                                count_next  = count_reg + 1'b1;
                                status_next = ST_DONE;
                                value_next  = item_value;
                            end
                            else if (ins_pos == count_reg)
                            begin
                                req.wr_en   = 1'b1;
                                req.wr_idx  = count_reg;
                                req.wr_data = item_value;
                                count_next  = count_reg + 1'b1;
                                status_next = ST_DONE;
                                value_next  = item_value;
                                rpos_next   = ins_pos[IDX_W-1:0];
                            end
                            else
                            begin
                                // move the tail up one place, last entry first
                                done_next  = 1'b0;
                                state_next = S_WALK;
                                pos_next   = ins_pos;
                                cur_next   = count_reg - 1'b1;
                                stop_next  = ins_pos;
                                up_next    = 1'b0;
                                more_next  = 1'b1;
                            end
                        end
                        OP_DEL_FRONT, OP_DEL_END, OP_DEL_AT:
                        begin
                            priority if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                                value_next  = '0;
                                rpos_next   = '0;
                                last_next   = 1'b1;
                            end
                            else if (mode == OP_DEL_AT && position >= count_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BAD_POS;
                                value_next  = '0;
                                rpos_next   = '0;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                req.rd_en  = 1'b1;
                                req.rd_idx = del_pos;
                                pos_next   = del_pos;
                                state_next = S_FETCH;
                            end
                        end
                        OP_SEARCH, OP_LIST_FWD, OP_LIST_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                                value_next  = '0;
                                rpos_next   = '0;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_WALK;
                                more_next  = 1'b1;
                                if (mode == OP_LIST_BACK)
                                begin
                                    cur_next  = count_reg - 1'b1;
                                    stop_next = '0;
                                    up_next   = 1'b0;
                                end
                                else
                                begin
                                    cur_next  = '0;
                                    stop_next = count_reg - 1'b1;
                                    up_next   = 1'b1;
                                end
                            end
                        end
                        OP_COUNT:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_DONE;
                            value_next  = '0;
                            rpos_next   = '0;
                            last_next   = 1'b1;
                        end
                        default:
                        begin
                            // unused codes are dropped
                            mode_next = mode_reg;
                            item_next = item_reg;
                        end
                    endcase
                end
            end

            S_FETCH:
            begin
                val_next = rd_data;
                priority if (pos_reg == '0)
                begin
                    ring_next   = (ring_reg == IDX_W'(CAPACITY - 1)) ? '0 : ring_reg + 1'b1;
                    count_next  = count_reg - 1'b1;
                    done_next   = 1'b1;
                    status_next = ST_DONE;
                    value_next  = rd_data;
                    rpos_next   = '0;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (pos_reg == count_reg - 1'b1)
                begin
                    count_next  = count_reg - 1'b1;
                    done_next   = 1'b1;
                    status_next = ST_DONE;
                    value_next  = rd_data;
                    rpos_next   = pos_reg[IDX_W-1:0];
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    // close the gap, first entry behind the target first
                    state_next = S_WALK;
                    cur_next   = pos_reg + 1'b1;
                    stop_next  = count_reg - 1'b1;
                    up_next    = 1'b1;
                    more_next  = 1'b1;
                    pend_next  = 1'b0;
                end
            end

            S_WALK:
            begin
                // issue side: one read per cycle
                if (more_reg)
                begin
                    req.rd_en     = 1'b1;
                    req.rd_idx    = cur_reg;
                    pend_next     = 1'b1;
                    pend_idx_next = cur_reg;
                    if (cur_reg == stop_reg)
                    begin
                        more_next = 1'b0;
                    end
                    else
                    begin
                        cur_next = up_reg ? cur_reg + 1'b1 : cur_reg - 1'b1;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // data side: handle the word read last cycle
                if (pend_reg)
                begin
                    unique case (mode_reg)
                        OP_SEARCH:
                        begin
                            if (rd_data == item_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_DONE;
                                value_next  = rd_data;
                                rpos_next   = pend_idx_reg[IDX_W-1:0];
                                last_next   = 1'b1;
                                state_next  = S_IDLE;
                                more_next   = 1'b0;
                                pend_next   = 1'b0;
                            end
                            else if (pend_idx_reg == stop_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOT_FOUND;
                                value_next  = '0;
                                rpos_next   = '0;
                                last_next   = 1'b1;
                                state_next  = S_IDLE;
                            end
                        end
                        OP_LIST_FWD, OP_LIST_BACK:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_DONE;
                            value_next  = rd_data;
                            rpos_next   = pend_idx_reg[IDX_W-1:0];
                            last_next   = (pend_idx_reg == stop_reg);
                            if (pend_idx_reg == stop_reg)
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        default:
                        begin
                            // tail move: write one place toward the gap
                            req.wr_en   = 1'b1;
                            req.wr_idx  = up_reg ? pend_idx_reg - 1'b1 : pend_idx_reg + 1'b1;
                            req.wr_data = rd_data;
                        end
                    endcase
                end

                // tail move drained: finish the insert or delete
                if (!more_reg && !pend_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_DONE;
                    rpos_next   = pos_reg[IDX_W-1:0];
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                    if (mode_reg == OP_INS_AT)
                    begin
                        req.wr_en   = 1'b1;
                        req.wr_idx  = pos_reg;
                        req.wr_data = item_reg;
                        count_next  = count_reg + 1'b1;
                        value_next  = item_reg;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        value_next = val_reg;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ring_reg  <= '0;
            more_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ring_reg  <= ring_next;
            more_reg  <= more_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        item_reg     <= item_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        cur_reg      <= cur_next;
        stop_reg     <= stop_next;
        up_reg       <= up_next;
        pend_idx_reg <= pend_idx_next;
        status_reg   <= status_next;
        value_reg    <= value_next;
        rpos_reg     <= rpos_next;
        last_reg     <= last_next;
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign result_value    = value_reg;
    assign result_position = rpos_reg;
    assign entry_count     = count_reg;
    assign last            = last_reg;

    // count never passes the store size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    // count moves by at most one per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg) || count_reg == $past(count_reg) + 1
                  || count_reg == $past(count_reg) - 1))
        else $error("entry count jumped");

    // a failed request gives a single cleared result
    a_fail_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ST_DONE) |-> (last_reg && value_reg == '0 && rpos_reg == '0))
        else $error("failed request result not cleared");

    // walk cursor stays inside the held entries
    a_walk_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && more_reg) |-> (cur_reg < count_reg))
        else $error("walk cursor outside held entries");

endmodule

[src/ple_store.sv]
// entry store of the positional list engine: ring address mapping and the word memory
// depends on ple_pkg

module ple_store
    import ple_pkg::*;
(
    input  logic                 clk,
    input  logic [IDX_W-1:0]     ring,
    input  ple_mem_req_t         req,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [CAPACITY];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     wr_addr;

    assign rd_addr = ring_idx(ring, req.rd_idx);
    assign wr_addr = ring_idx(ring, req.wr_idx);

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sim/testbench.sv]
// self-checking testbench for positional_list_engine: directed table, random requests, fill, full store, random again
// depends on ple_pkg and the positional_list_engine rtl, nothing else
`timescale 1ns / 100ps

module testbench
    import ple_pkg::*;
();

    // request codes the block ignores (no result, no state change)
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd10;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

    localparam int RANDOM_ITEMS = 110;      // per random phase, two phases
    localparam int CYCLE_LIMIT  = 400000;   // watchdog, far above the slowest legal run
    localparam int SETTLE_WAIT  = 200;      // longer than one full-length shift or listing
    localparam int DRAIN_LIMIT  = 20000;
    localparam int REPORT_LIMIT = 40;

    // one result as the block presents it
    typedef struct packed {
        logic [STATUS_W-1:0]         status;
        logic signed [WORD_BITS-1:0] value;
        logic [IDX_W-1:0]            pos;
        logic [CNT_W-1:0]            count;
        logic                        last;
    } list_result_t;

    // one row of the directed table; typed rows carry their result, others use the predictor
    typedef struct {
        logic [MODE_W-1:0]           op;
        logic [CNT_W-1:0]            where;
        logic signed [WORD_BITS-1:0] word;
        bit                          typed;
        list_result_t                want;
    } request_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic [MODE_W-1:0]           mode = '0;
    logic [CNT_W-1:0]            position = '0;
    logic signed [WORD_BITS-1:0] item_value = '0;
    logic                        busy;
    logic                        done;
    logic [STATUS_W-1:0]         status;
    logic signed [WORD_BITS-1:0] result_value;
    logic [IDX_W-1:0]            result_position;
    logic [CNT_W-1:0]            entry_count;
    logic                        last;

    // predictor state: the sequence in logical order, front first
    logic signed [WORD_BITS-1:0] held_words[$];
    // results the predictor produced for the request just accepted
    list_result_t                fresh_results[$];
    // results still owed by the block, oldest first
    list_result_t                pending_results[$];

    request_row_t                directed_rows[$];
    list_result_t                seen;
    list_result_t                oldest;
    int                          error_count = 0;
    int                          cycle_count = 0;
    bit                          quiet_stretch = 1'b0;

    positional_list_engine dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .mode            (mode),
        .position        (position),
        .item_value      (item_value),
        .done            (done),
        .status          (status),
        .result_value    (result_value),
        .result_position (result_position),
        .entry_count     (entry_count),
        .last            (last)
    );

    always #5 clk = ~clk;

    // watchdog: a hung handshake or a missing result ends here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // result with the entry count taken after the operation
    function automatic list_result_t make_result(input logic [STATUS_W-1:0] st,
                                                 input logic signed [WORD_BITS-1:0] val,
                                                 input int at, input bit fin);
        list_result_t r;
        r.status = st;
        r.value  = val;
        r.pos    = IDX_W'(at);
        r.count  = CNT_W'(held_words.size());
        r.last   = fin;
        return r;
    endfunction

    // predictor: apply one request to the sequence and collect the results it causes
    task automatic model_request(input logic [MODE_W-1:0] op, input logic [CNT_W-1:0] where,
                                 input logic signed [WORD_BITS-1:0] word);
        int                          n;
        int                          p;
        int                          i;
        bit                          hit;
        logic signed [WORD_BITS-1:0] taken;
        n = held_words.size();
        fresh_results.delete();
        case (op)
            OP_INS_FRONT, OP_INS_END, OP_INS_AT:
            begin
                p = (op == OP_INS_FRONT) ? 0 : (op == OP_INS_END) ? n : int'(where);
                // position is checked before fullness
                if (p > n)
                    fresh_results.push_back(make_result(ST_BAD_POS, '0, 0, 1'b1));
                else if (n >= CAPACITY)
                    fresh_results.push_back(make_result(ST_FULL, '0, 0, 1'b1));
                else
                begin
                    if (p == n)
                        held_words.push_back(word);
                    else
                        held_words.insert(p, word);
                    fresh_results.push_back(make_result(ST_DONE, word, p, 1'b1));
                end
            end
            OP_DEL_FRONT, OP_DEL_END, OP_DEL_AT:
            begin
                p = (op == OP_DEL_FRONT) ? 0 : (op == OP_DEL_END) ? n - 1 : int'(where);
                if (n == 0)
                    fresh_results.push_back(make_result(ST_EMPTY, '0, 0, 1'b1));
                else if (p >= n)
                    fresh_results.push_back(make_result(ST_BAD_POS, '0, 0, 1'b1));
                else
                begin
                    taken = held_words[p];
                    held_words.delete(p);
                    fresh_results.push_back(make_result(ST_DONE, taken, p, 1'b1));
                end
            end
            OP_SEARCH:
            begin
                hit = 1'b0;
                if (n == 0)
                    fresh_results.push_back(make_result(ST_EMPTY, '0, 0, 1'b1));
                else
                begin
                    for (i = 0; i < n && !hit; i++)
                    begin
                        if (held_words[i] == word)
                        begin
                            hit = 1'b1;
                            fresh_results.push_back(make_result(ST_DONE, word, i, 1'b1));
                        end
                    end
                    if (!hit)
                        fresh_results.push_back(make_result(ST_NOT_FOUND, '0, 0, 1'b1));
                end
            end
            OP_LIST_FWD, OP_LIST_BACK:
            begin
                if (n == 0)
                    fresh_results.push_back(make_result(ST_EMPTY, '0, 0, 1'b1));
                for (i = 0; i < n; i++)
                begin
                    p = (op == OP_LIST_FWD) ? i : n - 1 - i;
                    fresh_results.push_back(make_result(ST_DONE, held_words[p], p,
                                                        i == n - 1));
                end
            end
            OP_COUNT:
                fresh_results.push_back(make_result(ST_DONE, '0, 0, 1'b1));
            default:
                ;   // unused codes: nothing happens
        endcase
    endtask

    function automatic request_row_t mk_row(input logic [MODE_W-1:0] op,
                                            input logic [CNT_W-1:0] where,
                                            input logic signed [WORD_BITS-1:0] word,
                                            input bit typed,
                                            input logic [STATUS_W-1:0] st,
                                            input logic signed [WORD_BITS-1:0] val,
                                            input int at, input int cnt);
        request_row_t r;
        r.op          = op;
        r.where       = where;
        r.word        = word;
        r.typed       = typed;
        r.want.status = st;
        r.want.value  = val;
        r.want.pos    = IDX_W'(at);
        r.want.count  = CNT_W'(cnt);
        r.want.last   = 1'b1;
        return r;
    endfunction

    // idle cycles before the next request; some stretches run back to back
    function automatic int pick_gap();
        return quiet_stretch ? 0 : int'($urandom_range(0, 3));
    endfunction

    // drive one request, hold it until accepted, then log what the block owes
    // entered and left at a rising edge at which start has not been assigned yet
    task automatic issue_request(input logic [MODE_W-1:0] op, input logic [CNT_W-1:0] where,
                                 input logic signed [WORD_BITS-1:0] word, input int gap,
                                 input bit typed, input list_result_t want);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        mode       <= op;
        position   <= where;
        item_value <= word;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        // accept edge
        model_request(op, where, word);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (fresh_results[k])
                pending_results.push_back(fresh_results[k]);
    endtask

    // one random request, shaped by how full the sequence is
    task automatic random_request(output bit counted);
        int                          n;
        int                          pick;
        logic [MODE_W-1:0]           op;
        logic [CNT_W-1:0]            where;
        logic signed [WORD_BITS-1:0] word;
        n = held_words.size();
        pick = $urandom_range(0, 99);
        if (pick < 3)
            op = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        else if (pick < ((n < 8) ? 60 : 40))
            op = MODE_W'($urandom_range(OP_INS_FRONT, OP_INS_AT));
        else if (pick < 75)
            op = MODE_W'($urandom_range(OP_DEL_FRONT, OP_DEL_AT));
        else if (pick < 88)
            op = OP_SEARCH;
        else if (pick < 95)
            op = MODE_W'($urandom_range(OP_LIST_FWD, OP_LIST_BACK));
        else
            op = OP_COUNT;

        // mostly legal positions, some anywhere from 0 to CAPACITY
        if ($urandom_range(0, 9) == 0)
            where = CNT_W'($urandom_range(0, CAPACITY));
        else if ((op == OP_DEL_AT) && (n > 0))
            where = CNT_W'($urandom_range(0, n - 1));
        else
            where = CNT_W'($urandom_range(0, n));

        // small values repeat, so searches find duplicates and misses alike
        case ($urandom_range(0, 3))
            0: word = $urandom;
            1: word = WORD_BITS'(int'($urandom_range(0, 6)) - 3);
            2: word = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: word = (n > 0) ? held_words[$urandom_range(0, n - 1)] : $urandom;
        endcase

        counted = (op < MODE_UNUSED_LO);
        issue_request(op, where, word, pick_gap(), 1'b0, '0);
    endtask

    task automatic random_phase(input int items);
        int sent;
        bit counted;
        sent = 0;
        while (sent < items)
        begin
            if (sent % 16 == 0)
                quiet_stretch = ($urandom_range(0, 3) == 0);
            random_request(counted);
            if (counted)
                sent++;
        end
    endtask

    // hold off until the block owes nothing, then let any internal shift finish
    task automatic wait_idle();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
    endtask

    // result checker: every strobe must match the oldest owed result
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            seen = {status, result_value, result_position, entry_count, last};
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result, expected none, actual %0h", $time, seen);
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (seen.status !== oldest.status)
                    note_mismatch("status", oldest.status, seen.status);
                if (seen.value !== oldest.value)
                    note_mismatch("result_value", oldest.value, seen.value);
                if (seen.pos !== oldest.pos)
                    note_mismatch("result_position", oldest.pos, seen.pos);
                if (seen.count !== oldest.count)
                    note_mismatch("entry_count", oldest.count, seen.count);
                if (seen.last !== oldest.last)
                    note_mismatch("last", oldest.last, seen.last);
            end
        end
    end

    initial
    begin
        // empty list: every request that needs an entry is refused
        directed_rows.push_back(mk_row(OP_COUNT,     0, 0, 1, ST_DONE,    0, 0, 0));
        directed_rows.push_back(mk_row(OP_DEL_FRONT, 0, 0, 1, ST_EMPTY,   0, 0, 0));
        directed_rows.push_back(mk_row(OP_DEL_END,   0, 0, 1, ST_EMPTY,   0, 0, 0));
        directed_rows.push_back(mk_row(OP_DEL_AT,    0, 0, 1, ST_EMPTY,   0, 0, 0));
        directed_rows.push_back(mk_row(OP_SEARCH,    0, 0, 1, ST_EMPTY,   0, 0, 0));
        directed_rows.push_back(mk_row(OP_LIST_FWD,  0, 0, 1, ST_EMPTY,   0, 0, 0));
        directed_rows.push_back(mk_row(OP_LIST_BACK, 0, 0, 1, ST_EMPTY,   0, 0, 0));
        // insert past the end, including position 64, the capacity
        directed_rows.push_back(mk_row(OP_INS_AT,    1, 0, 1, ST_BAD_POS, 0, 0, 0));
        directed_rows.push_back(mk_row(OP_INS_AT,   64, 0, 1, ST_BAD_POS, 0, 0, 0));
        // insert at 0 into an empty list is legal
        directed_rows.push_back(mk_row(OP_INS_AT,    0, 5, 1, ST_DONE,    5, 0, 1));
        // delete at count is refused, then a one-entry list empties
        directed_rows.push_back(mk_row(OP_DEL_AT,    1, 0, 1, ST_BAD_POS, 0, 0, 1));
        directed_rows.push_back(mk_row(OP_DEL_AT,    0, 0, 1, ST_DONE,    5, 0, 0));
        directed_rows.push_back(mk_row(OP_INS_END,   0, 9, 1, ST_DONE,    9, 0, 1));
        directed_rows.push_back(mk_row(OP_DEL_END,   0, 0, 1, ST_DONE,    9, 0, 0));
        // value extremes
        directed_rows.push_back(mk_row(OP_INS_FRONT, 0, 32'h7fff_ffff, 1, ST_DONE,
                                       32'h7fff_ffff, 0, 1));
        directed_rows.push_back(mk_row(OP_INS_END,   0, 32'h8000_0000, 1, ST_DONE,
                                       32'h8000_0000, 1, 2));
        directed_rows.push_back(mk_row(OP_INS_AT,    1, -1, 1, ST_DONE,   -1, 1, 3));
        directed_rows.push_back(mk_row(OP_INS_AT,    3, 0, 1, ST_DONE,    0, 3, 4));
        // insert at 0 on a non-empty list moves the ring start
        directed_rows.push_back(mk_row(OP_INS_AT,    0, 32'h5a5a_a5a5, 1, ST_DONE,
                                       32'h5a5a_a5a5, 0, 5));
        directed_rows.push_back(mk_row(OP_SEARCH,    0, -1, 0, ST_DONE,   0, 0, 0));
        directed_rows.push_back(mk_row(OP_SEARCH,    0, 12345, 1, ST_NOT_FOUND, 0, 0, 5));
        directed_rows.push_back(mk_row(OP_LIST_FWD,  0, 0, 0, ST_DONE,    0, 0, 0));
        directed_rows.push_back(mk_row(OP_LIST_BACK, 0, 0, 0, ST_DONE,    0, 0, 0));
        directed_rows.push_back(mk_row(OP_DEL_AT,    2, 0, 0, ST_DONE,    0, 0, 0));
        // unused codes are dropped silently
        directed_rows.push_back(mk_row(MODE_UNUSED_LO, 0, 0, 0, ST_DONE,  0, 0, 0));
        directed_rows.push_back(mk_row(MODE_UNUSED_HI, 0, 0, 0, ST_DONE,  0, 0, 0));
        directed_rows.push_back(mk_row(OP_DEL_END,   0, 0, 0, ST_DONE,    0, 0, 0));
        directed_rows.push_back(mk_row(OP_DEL_AT,   64, 0, 1, ST_BAD_POS, 0, 0, 3));

        // single reset at the start of the run
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            issue_request(directed_rows[r].op, directed_rows[r].where, directed_rows[r].word,
                          pick_gap(), directed_rows[r].typed, directed_rows[r].want);

        random_phase(RANDOM_ITEMS);

        // sender holds off until every owed result has come
        wait_idle();

        // fill to capacity with inserts at random places
        quiet_stretch = 1'b0;
        while (held_words.size() < CAPACITY)
            issue_request(MODE_W'($urandom_range(OP_INS_FRONT, OP_INS_AT)),
                          CNT_W'($urandom_range(0, held_words.size())), $urandom,
                          pick_gap(), 1'b0, '0);

        // full store: inserts refused, full-length walks, edge positions
        issue_request(OP_INS_FRONT, 0, 1, pick_gap(), 1'b0, '0);
        issue_request(OP_INS_END, 0, 2, pick_gap(), 1'b0, '0);
        issue_request(OP_INS_AT, 64, 3, pick_gap(), 1'b0, '0);
        issue_request(OP_LIST_FWD, 0, 0, pick_gap(), 1'b0, '0);
        issue_request(OP_LIST_BACK, 0, 0, pick_gap(), 1'b0, '0);
        issue_request(OP_SEARCH, 0, held_words[CAPACITY - 1], pick_gap(), 1'b0, '0);
        issue_request(OP_COUNT, 0, 0, pick_gap(), 1'b0, '0);
        issue_request(OP_DEL_AT, 64, 0, pick_gap(), 1'b0, '0);
        issue_request(OP_DEL_AT, 63, 0, pick_gap(), 1'b0, '0);
        issue_request(OP_DEL_AT, 1, 0, pick_gap(), 1'b0, '0);
        issue_request(OP_INS_AT, 1, -7, pick_gap(), 1'b0, '0);
        issue_request(OP_INS_AT, 63, 77, pick_gap(), 1'b0, '0);
        issue_request(OP_DEL_FRONT, 0, 0, pick_gap(), 1'b0, '0);

        random_phase(RANDOM_ITEMS);

        // drain, then a quiet tail to catch stray strobes
        wait_idle();
        if (pending_results.size() != 0)
        begin
            error_count++;
            $display("%0t: results never arrived, expected %0d more, actual 0", $time,
                     pending_results.size());
        end

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[positional_list_engine.f]
src/ple_pkg.sv
src/ple_store.sv
src/positional_list_engine.sv
sim/testbench.sv
